[sv/dmc_pkg.sv]
// Shared constants for the direct-mapped write-back cache statistics core.
package dmc_pkg;

  // Address and counter widths
  localparam int ADDR_W = 32;
  localparam int CNT_W  = 32;
  localparam int BYTES_W = 4;
  localparam int PEN_W  = 10;
  localparam int IBITS_W = 4;

  // Default geometry
  localparam int DEF_OFFSET_BITS    = 4;
  localparam int DEF_MAX_INDEX_BITS = 12;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY    = 1'b1;
  localparam int CFG_DATA_W = 10;

  // Configuration reset values
  localparam logic [IBITS_W-1:0] RESET_INDEX_BITS = 4'd12;
  localparam logic [PEN_W-1:0]   RESET_PENALTY    = 10'd80;

  // Access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Statistics counter slots, in output order
  localparam int CNT_READS   = 0;
  localparam int CNT_WRITES  = 1;
  localparam int CNT_RMISS   = 2;
  localparam int CNT_WMISS   = 3;
  localparam int CNT_DRMISS  = 4;
  localparam int CNT_DWMISS  = 5;
  localparam int CNT_BYTES_R = 6;
  localparam int CNT_BYTES_W = 7;
  localparam int CNT_CYC_R   = 8;
  localparam int CNT_CYC_W   = 9;
  localparam int CNT_TOTAL   = 10;

  // Stream payload widths
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 328;
  localparam int OUT_BITS  = 2 + CNT_TOTAL * CNT_W;

  // Cycle cost arithmetic: 1 + 2 * penalty fits in PEN_W + 2 bits
  localparam int COST_W = PEN_W + 2;

endpackage

[sv/direct_mapped_writeback_cache_model_core.sv]
// Direct-mapped write-back write-allocate cache model: one access in, one statistics result out.
// Each accepted access (tuser[0] = write, tdata = address and size) yields one result, via the
// lookup and result registers, carrying hit, dirty-victim and ten wrapping 32-bit counters.
// Accesses are taken at one per cycle sustained while the result stream does not stall; the tag
// memory is read on acceptance and written back as the access leaves the lookup stage, with the
// last written line forwarded so back-to-back accesses to one line see the fresh state. After
// reset all 2**MAX_INDEX_BITS lines (4096 by default) are swept clear one line per cycle, with
// s_tready low and configuration writes still taken. Reconfigure only while no access is in flight.
module direct_mapped_writeback_cache_model_core #(
  parameter int OFFSET_BITS    = dmc_pkg::DEF_OFFSET_BITS,
  parameter int MAX_INDEX_BITS = dmc_pkg::DEF_MAX_INDEX_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [dmc_pkg::S_TDATA_W-1:0]       s_tdata,  // address[31:0], access_bytes[35:32], zero pad
  input  logic [0:0]                          s_tuser,  // cmd (0 read, 1 write)
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [dmc_pkg::M_TDATA_W-1:0]       m_tdata,  // hit, dirty_victim, then ten counters
                                                        // from read_count up, zero pad
  // Configuration write port
  input  logic                                cfg_wen,
  input  logic [dmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int BLK_W  = dmc_pkg::ADDR_W - OFFSET_BITS;
  localparam int TAG_W  = BLK_W;
  localparam int WORD_W = TAG_W + 2;
  localparam int IDX_W  = MAX_INDEX_BITS;
  localparam int IB_W   = $clog2(MAX_INDEX_BITS + 1);

  // Configuration registers
  logic [dmc_pkg::IBITS_W-1:0] index_bits;
  logic [dmc_pkg::PEN_W-1:0]   penalty;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= dmc_pkg::RESET_INDEX_BITS;
      penalty    <= dmc_pkg::RESET_PENALTY;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        dmc_pkg::REG_INDEX_BITS: index_bits <= cfg_data[dmc_pkg::IBITS_W-1:0];
        dmc_pkg::REG_PENALTY:    penalty    <= cfg_data[dmc_pkg::PEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Address split for the incoming access
  logic [IB_W-1:0]  ib;
  logic [BLK_W-1:0] in_blk;
  logic [IDX_W-1:0] in_idx;
  logic [TAG_W-1:0] in_tag;

  always_comb begin
    if (int'(index_bits) > MAX_INDEX_BITS) begin
      ib = IB_W'(MAX_INDEX_BITS);
    end else begin
      ib = IB_W'(index_bits);
    end
    in_blk = s_tdata[dmc_pkg::ADDR_W-1:OFFSET_BITS];
    for (int i = 0; i < IDX_W; i++) begin
      in_idx[i] = in_blk[i] && (i < int'(ib));
    end
    in_tag = in_blk >> ib;
  end

  // Handshake
  logic store_busy;
  logic s1_vld;
  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free = !m_tvalid || m_tready;
  assign s1_fire  = s1_vld && out_free;
  assign s_tready = !store_busy && (!s1_vld || out_free);
  assign in_fire  = s_tvalid && s_tready;

  // Lookup stage registers
  logic                        s1_cmd;
  logic [IDX_W-1:0]            s1_idx;
  logic [TAG_W-1:0]            s1_tag;
  logic [dmc_pkg::BYTES_W-1:0] s1_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (in_fire) begin
      s1_vld <= 1'b1;
    end else if (s1_fire) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd   <= s_tuser[0];
      s1_idx   <= in_idx;
      s1_tag   <= in_tag;
      s1_bytes <= s_tdata[dmc_pkg::ADDR_W +: dmc_pkg::BYTES_W];
    end
  end

  // Tag memory
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] wr_word;

  dmc_tag_store #(
    .IDX_W  (IDX_W),
    .WORD_W (WORD_W)
  ) u_tag_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_idx  (in_idx),
    .rd_word (rd_word),
    .wr_en   (s1_fire),
    .wr_idx  (s1_idx),
    .wr_word (wr_word),
    .busy    (store_busy)
  );

  // Last written line, forwarded over the read-during-write window
  logic              fwd_vld;
  logic [IDX_W-1:0]  fwd_idx;
  logic [WORD_W-1:0] fwd_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_vld <= 1'b0;
    end else if (s1_fire) begin
      fwd_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fwd_idx  <= s1_idx;
      fwd_word <= wr_word;
    end
  end

  // Hit check and line update
  logic [WORD_W-1:0]           cur_word;
  logic                        cur_valid;
  logic                        cur_dirty;
  logic                        hit;
  logic                        dirty_victim;
  logic                        new_dirty;
  logic [dmc_pkg::COST_W-1:0]  cost;

  always_comb begin
    if (fwd_vld && (fwd_idx == s1_idx)) begin
      cur_word = fwd_word;
    end else begin
      cur_word = rd_word;
    end
    cur_valid    = cur_word[WORD_W-1];
    cur_dirty    = cur_word[WORD_W-2];
    hit          = cur_valid && (cur_word[TAG_W-1:0] == s1_tag);
    dirty_victim = !hit && cur_valid && cur_dirty;
    // reads keep the dirty bit on a hit and refill clean on a miss
    if (s1_cmd == dmc_pkg::CMD_WRITE) begin
      new_dirty = 1'b1;
    end else begin
      new_dirty = hit && cur_dirty;
    end
    wr_word = {1'b1, new_dirty, s1_tag};
    if (hit) begin
      cost = dmc_pkg::COST_W'(1);
    end else if (dirty_victim) begin
      cost = dmc_pkg::COST_W'(1) + dmc_pkg::COST_W'(penalty)
             + dmc_pkg::COST_W'(penalty);
    end else begin
      cost = dmc_pkg::COST_W'(1) + dmc_pkg::COST_W'(penalty);
    end
  end

  // Statistics counters and result flags
  logic [dmc_pkg::CNT_W-1:0] stats [dmc_pkg::CNT_TOTAL];
  logic                      res_hit;
  logic                      res_dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < dmc_pkg::CNT_TOTAL; k++) begin
        stats[k] <= '0;
      end
    end else if (s1_fire) begin
      if (s1_cmd == dmc_pkg::CMD_READ) begin
        stats[dmc_pkg::CNT_READS] <= stats[dmc_pkg::CNT_READS] + dmc_pkg::CNT_W'(1);
        stats[dmc_pkg::CNT_CYC_R] <= stats[dmc_pkg::CNT_CYC_R] + dmc_pkg::CNT_W'(cost);
        if (!hit) begin
          stats[dmc_pkg::CNT_RMISS]   <= stats[dmc_pkg::CNT_RMISS] + dmc_pkg::CNT_W'(1);
          stats[dmc_pkg::CNT_BYTES_R] <= stats[dmc_pkg::CNT_BYTES_R]
                                         + dmc_pkg::CNT_W'(s1_bytes);
        end
        if (dirty_victim) begin
          stats[dmc_pkg::CNT_DRMISS] <= stats[dmc_pkg::CNT_DRMISS] + dmc_pkg::CNT_W'(1);
        end
      end else begin
        stats[dmc_pkg::CNT_WRITES] <= stats[dmc_pkg::CNT_WRITES] + dmc_pkg::CNT_W'(1);
        stats[dmc_pkg::CNT_CYC_W]  <= stats[dmc_pkg::CNT_CYC_W] + dmc_pkg::CNT_W'(cost);
        if (!hit) begin
          stats[dmc_pkg::CNT_WMISS]   <= stats[dmc_pkg::CNT_WMISS] + dmc_pkg::CNT_W'(1);
          stats[dmc_pkg::CNT_BYTES_W] <= stats[dmc_pkg::CNT_BYTES_W]
                                         + dmc_pkg::CNT_W'(s1_bytes);
        end
        if (dirty_victim) begin
          stats[dmc_pkg::CNT_DWMISS] <= stats[dmc_pkg::CNT_DWMISS] + dmc_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_hit <= hit;
      res_dv  <= dirty_victim;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload straight from the counter registers
  always_comb begin
    m_tdata    = '0;
    m_tdata[0] = res_hit;
    m_tdata[1] = res_dv;
    for (int k = 0; k < dmc_pkg::CNT_TOTAL; k++) begin
      m_tdata[2 + k * dmc_pkg::CNT_W +: dmc_pkg::CNT_W] = stats[k];
    end
  end

endmodule

[sv/dmc_tag_store.sv]
// Tag store memory: valid, dirty and tag per line, with a clearing pass after reset.
module dmc_tag_store #(
  parameter int IDX_W  = 12,
  parameter int WORD_W = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [WORD_W-1:0] rd_word,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [WORD_W-1:0] wr_word,
  output logic              busy
);

  localparam int DEPTH = 1 << IDX_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0]  clr_idx;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [WORD_W-1:0] mem_wd;

  // Clearing sweep owns the write port while busy
  always_comb begin
    if (busy) begin
      mem_we = 1'b1;
      mem_wa = clr_idx;
      mem_wd = '0;
    end else begin
      mem_we = wr_en;
      mem_wa = wr_idx;
      mem_wd = wr_word;
    end
  end

  // Sweep counter: one line per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + IDX_W'(1);
      if (clr_idx == {IDX_W{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_word <= mem[rd_idx];
    end
  end

endmodule
